/* rtl/vrrb_pkg.sv */
// ----------------------------------------------------------------------------
// vrrb_pkg
// Shared types and constants for the round-robin connection balancer.
// ----------------------------------------------------------------------------
package vrrb_pkg;

  localparam int POOL_ENTRIES  = 256;
  localparam int POOL_BACKENDS = 16;
  localparam int STATS_ENTRIES = 256;
  localparam int PW = $clog2(POOL_ENTRIES);
  localparam int BW = $clog2(POOL_BACKENDS);
  localparam int SW = $clog2(STATS_ENTRIES);

  localparam logic [1:0] KIND_CONNECT = 2'd0;
  localparam logic [1:0] KIND_POOL    = 2'd1;
  localparam logic [1:0] KIND_BACKEND = 2'd2;

  localparam logic [2:0] ST_WRITE    = 3'd0;
  localparam logic [2:0] ST_NOMATCH  = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_ZERO     = 3'd3;
  localparam logic [2:0] ST_REDIRECT = 3'd4;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] dest_addr;
    logic [15:0] dest_port;
    logic [7:0]  vip_slot;
    logic        entry_valid;
    logic [4:0]  pool_count;
    logic [3:0]  backend_index;
    logic [31:0] backend_addr;
  } in_item_t;

  typedef struct packed {
    logic [31:0] new_addr;
    logic [2:0]  status;
    logic [3:0]  chosen_index;
    logic [63:0] conn_count;
    logic        stats_replaced;
  } out_item_t;

  // front result handed to the stats engine
  typedef struct packed {
    logic        need_stats;
    logic [47:0] key;
    out_item_t   res;
  } job_t;

endpackage

/* rtl/vip_round_robin_balancer_top.sv */
// ----------------------------------------------------------------------------
// vip_round_robin_balancer_top
// Round-robin connection balancer with per-backend connection statistics.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_item take connect requests and pool/backend writes.
//   out_valid/out_ready/out_item return exactly one result per item.
//   A connect request scans the pool key table one slot per cycle (up to
//   POOL_ENTRIES slots), then reads the backend memory.
//   A redirected request then runs the stats engine: one search sweep and
//   one age-update sweep over STATS_ENTRIES entries. The pool lookup and
//   stats engine are separated by a two-entry queue, so lookup continues
//   while stats work. Reset clears the pool and stats valid bits; size,
//   position and counter of an entry are loaded when it is written, so no
//   clearing pass. A stalled receiver holds out_item and backs up through
//   the queue to in_ready.
// ----------------------------------------------------------------------------
module vip_round_robin_balancer_top import vrrb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic f_valid, f_ready, q_valid, q_ready;
  job_t f_job, q_job;

  vrrb_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_item,
    .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
  );

  vrrb_fifo u_fifo (
    .clk, .rst_n, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_job),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_job)
  );

  vrrb_stats u_stats (
    .clk, .rst_n, .job_valid(q_valid), .job_ready(q_ready), .job(q_job),
    .out_valid, .out_ready, .out_item
  );

endmodule

/* rtl/vrrb_front.sv */
// ----------------------------------------------------------------------------
// vrrb_front
// Pool table: writes, sequential key search, round-robin pick.
// ----------------------------------------------------------------------------
module vrrb_front import vrrb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      job_valid,
  input  logic      job_ready,
  output job_t      job
);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_BREAD, S_BWAIT, S_OUT} state_t;

  state_t state_r;
  in_item_t item_r;
  logic [PW-1:0] idx_r;
  logic [PW-1:0] hit_r;
  logic [BW-1:0] pick_r;
  logic [PW:0]   cnt_r;
  logic [4:0]    sz_r;
  logic [BW-1:0] rrp_r;
  job_t job_r;

  logic [31:0] key_mem   [POOL_ENTRIES];
  logic [31:0] be_mem    [POOL_ENTRIES*POOL_BACKENDS];
  logic [4:0]  psize_mem [POOL_ENTRIES];
  logic [BW-1:0] rr_mem  [POOL_ENTRIES];
  logic [31:0] key_q, be_q;
  logic [4:0]  sz_q;
  logic [BW-1:0] rrp_q;
  logic [POOL_ENTRIES-1:0] pvalid_r;

  logic [PW-1:0] rd_idx;
  logic [4:0] nsz;
  logic [BW:0] nclip;
  logic [BW:0] nextp;
  logic [BW-1:0] rr_upd;
  logic wr_slot_ok;

  assign in_ready  = (state_r == S_IDLE);
  assign job_valid = (state_r == S_OUT) && (cnt_r != '0);
  assign job       = job_r;

  assign rd_idx = (state_r == S_IDLE) ? {PW{1'b0}} : idx_r;
  assign nsz    = sz_r;
  assign nclip  = (nsz > 5'(POOL_BACKENDS)) ? (BW+1)'(POOL_BACKENDS) : (BW+1)'(nsz);
  assign wr_slot_ok = ({1'b0, in_item.vip_slot} < 9'(POOL_ENTRIES));
  assign rr_upd = ((nextp + 1'b1) == nclip) ? '0 : BW'(nextp + 1'b1);

  always_comb begin
    nextp = (BW+1)'(rrp_r);
    if (nextp >= nclip) nextp = nextp - nclip;
  end

  always_ff @(posedge clk) begin
    key_q <= key_mem[rd_idx];
    sz_q  <= psize_mem[rd_idx];
    rrp_q <= rr_mem[rd_idx];
    be_q  <= be_mem[{hit_r, pick_r}];
    if (state_r == S_IDLE && in_valid) begin
      if (in_item.kind == KIND_POOL && wr_slot_ok) begin
        key_mem[PW'(in_item.vip_slot)]   <= in_item.dest_addr;
        psize_mem[PW'(in_item.vip_slot)] <= in_item.pool_count;
        rr_mem[PW'(in_item.vip_slot)]    <= '0;
      end
      if (in_item.kind == KIND_BACKEND && wr_slot_ok &&
          {1'b0, in_item.backend_index} < 5'(POOL_BACKENDS))
        be_mem[{PW'(in_item.vip_slot), BW'(in_item.backend_index)}] <= in_item.backend_addr;
    end
    if (state_r == S_BREAD && nsz != 5'd0) rr_mem[hit_r] <= rr_upd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      pvalid_r <= '0;
      idx_r    <= '0;
      cnt_r    <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            item_r <= in_item;
            job_r  <= {1'b0, 48'd0, in_item.dest_addr, ST_WRITE, 4'd0, 64'd0, 1'b0};
            if (in_item.kind == KIND_CONNECT) begin
              idx_r   <= PW'(1);
              cnt_r   <= '0;
              state_r <= S_SCAN;
            end else begin
              if (in_item.kind == KIND_POOL && wr_slot_ok)
                pvalid_r[PW'(in_item.vip_slot)] <= in_item.entry_valid;
              state_r <= S_OUT;
            end
          end
        end
        S_SCAN: begin
          // key_q, sz_q, rrp_q hold entry cnt_r
          if (pvalid_r[cnt_r[PW-1:0]] && key_q == item_r.dest_addr) begin
            hit_r   <= cnt_r[PW-1:0];
            sz_r    <= sz_q;
            rrp_r   <= rrp_q;
            state_r <= S_BREAD;
          end else if (cnt_r == (PW+1)'(POOL_ENTRIES - 1)) begin
            job_r.res.status <= ST_NOMATCH;
            state_r <= S_OUT;
          end else begin
            cnt_r <= cnt_r + 1'b1;
            idx_r <= idx_r + 1'b1;
          end
        end
        S_BREAD: begin
          if (nsz == 5'd0) begin
            job_r.res.status <= ST_EMPTY;
            state_r <= S_OUT;
          end else begin
            pick_r  <= BW'(nextp);
            state_r <= S_BWAIT;
          end
        end
        S_BWAIT: begin
          // be_q reads the entry at pick_r here and is valid in S_OUT
          state_r <= S_OUT;
          cnt_r   <= '0;
          job_r.res.chosen_index <= 4'(pick_r);
          job_r.res.status <= ST_ZERO;
        end
        S_OUT: begin
          if (cnt_r == '0 && job_r.res.status == ST_ZERO && be_q != 32'd0) begin
            job_r.res.status   <= ST_REDIRECT;
            job_r.res.new_addr <= be_q;
            job_r.need_stats   <= 1'b1;
            job_r.key          <= {be_q, item_r.dest_port};
          end
          cnt_r <= (PW+1)'(1);
          if (job_ready && cnt_r != '0) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/vrrb_stats.sv */
// ----------------------------------------------------------------------------
// vrrb_stats
// Associative connection counter with exact LRU, one entry per cycle.
// ----------------------------------------------------------------------------
module vrrb_stats import vrrb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      job_valid,
  output logic      job_ready,
  input  job_t      job,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  typedef enum logic [2:0] {S_IDLE, S_SRCH, S_UPD, S_AGE, S_OUT} state_t;

  state_t state_r;
  job_t   job_r;
  out_item_t res_r;
  logic [STATS_ENTRIES-1:0] sval_r;
  logic [47:0]   skey_mem  [STATS_ENTRIES];
  logic [63:0]   conns_mem [STATS_ENTRIES];
  logic [SW-1:0] age_mem   [STATS_ENTRIES];
  logic [47:0]   skey_q;
  logic [63:0]   conns_q;
  logic [SW-1:0] age_q;
  logic [SW:0] cnt_r;
  logic [SW-1:0] slot_r, free_r, old_r;
  logic [SW-1:0] ref_age_r, old_age_r;
  logic [63:0] hit_conns_r;
  logic found_r, have_free_r, have_old_r;
  logic [SW-1:0] ci, pi;
  logic [63:0] conns_inc;
  logic sweep_last;

  assign ci = cnt_r[SW-1:0];
  // entry whose registered read data is present this cycle
  assign pi = SW'(cnt_r - 1'b1);
  assign sweep_last = (cnt_r == (SW+1)'(STATS_ENTRIES));
  assign conns_inc  = (hit_conns_r != '1) ? hit_conns_r + 64'd1 : '1;
  assign job_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_item  = res_r;

  always_ff @(posedge clk) begin
    skey_q  <= skey_mem[ci];
    conns_q <= conns_mem[ci];
    age_q   <= age_mem[ci];
    if (state_r == S_AGE && cnt_r != '0) begin
      if (pi == slot_r)
        age_mem[pi] <= '0;
      else if (sval_r[pi] && (!found_r || age_q < ref_age_r))
        age_mem[pi] <= age_q + 1'b1;
    end
    if (state_r == S_UPD && found_r) begin
      conns_mem[slot_r] <= conns_inc;
    end else if (state_r == S_AGE && sweep_last && !found_r) begin
      conns_mem[slot_r] <= 64'd1;
      skey_mem[slot_r]  <= job_r.key;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sval_r  <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (job_valid) begin
            job_r <= job;
            res_r <= job.res;
            cnt_r <= '0;
            found_r <= 1'b0;
            have_free_r <= 1'b0;
            have_old_r <= 1'b0;
            state_r <= job.need_stats ? S_SRCH : S_OUT;
          end
        end
        S_SRCH: begin
          if (cnt_r != '0) begin
            if (sval_r[pi] && skey_q == job_r.key && !found_r) begin
              found_r     <= 1'b1;
              slot_r      <= pi;
              ref_age_r   <= age_q;
              hit_conns_r <= conns_q;
            end
            if (!sval_r[pi] && !have_free_r) begin
              have_free_r <= 1'b1;
              free_r      <= pi;
            end
            if (sval_r[pi] && (!have_old_r || age_q > old_age_r)) begin
              have_old_r <= 1'b1;
              old_age_r  <= age_q;
              old_r      <= pi;
            end
          end
          if (sweep_last) state_r <= S_UPD;
          else cnt_r <= cnt_r + 1'b1;
        end
        S_UPD: begin
          cnt_r <= '0;
          if (found_r) begin
            res_r.conn_count <= conns_inc;
          end else begin
            slot_r <= have_free_r ? free_r : old_r;
            res_r.conn_count <= 64'd1;
            res_r.stats_replaced <= !have_free_r;
          end
          state_r <= S_AGE;
        end
        S_AGE: begin
          if (sweep_last) begin
            if (!found_r) sval_r[slot_r] <= 1'b1;
            state_r <= S_OUT;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_OUT: if (out_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/vrrb_fifo.sv */
// ----------------------------------------------------------------------------
// vrrb_fifo
// Two-entry queue between pool lookup and stats engine.
// ----------------------------------------------------------------------------
module vrrb_fifo import vrrb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_ready,
  input  job_t wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output job_t rd_data
);

  job_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic wr_en, rd_en;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign wr_en = wr_valid && wr_ready;
  assign rd_en = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr_en) - 2'(rd_en);
    end
  end

endmodule

/* rtl/vrrb_checker.sv */
// ----------------------------------------------------------------------------
// vrrb_checker
// Port-level checks for the balancer.
// ----------------------------------------------------------------------------
module vrrb_checker import vrrb_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_item,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_item
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.status <= ST_REDIRECT)
    else $error("bad status");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status != ST_REDIRECT |-> out_item.conn_count == 64'd0)
    else $error("count without redirect");

  a_repl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.stats_replaced |-> out_item.conn_count == 64'd1)
    else $error("eviction with nonfresh count");

endmodule

bind vip_round_robin_balancer_top vrrb_checker u_chk (.*);
